// File: rtl/arc_triangle_fan_tessellator_unit_defines.svh
// Assertion macros for the arc triangle fan tessellator
`ifndef ARC_TRIANGLE_FAN_TESSELLATOR_UNIT_DEFINES_SVH
`define ARC_TRIANGLE_FAN_TESSELLATOR_UNIT_DEFINES_SVH
// implication checked at every clock edge outside reset
`define ATF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ATF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/atf_pkg.sv
// Shared constants, types and tables for the arc triangle fan tessellator
package atf_pkg;
  localparam int MaxSegments   = 64;
  localparam int MinSegments   = 3;
  localparam int CordicSteps   = 24;
  localparam int SegW          = 7;
  localparam int StepW         = $clog2(CordicSteps);
  localparam logic signed [33:0] GainInv = 34'sd652032874;

  // datapath commands
  typedef struct packed {
    logic load;        // capture request
    logic div_start;   // load arc*k numerator, clear divider state
    logic div_step;    // one restoring-divide step
    logic ang_load;    // form angle from quotient (k=0 uses start)
    logic cor_init;    // seed cordic
    logic cor_step;    // one cordic iteration
    logic mul_x;       // multiply for x
    logic mul_y;       // multiply for y
    logic place_x;     // add and saturate x
    logic place_y;     // add and saturate y
    logic emit;        // load output register
    logic shift_prev;  // next becomes prev
    logic k_inc;       // advance segment
  } atf_cmd_t;

  typedef struct packed {
    logic empty;       // request emits nothing
    logic div_done;
    logic cor_done;
    logic first;       // k is zero (start point)
    logic last;        // current k is final
    logic out_busy;    // output register occupied
  } atf_sts_t;

  function automatic logic [31:0] atan_lut(input logic [StepW-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'd536870912;   5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;   5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;    5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;    5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;     5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;     5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;     5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;       5'd19: v = 32'd1304;
      5'd20: v = 32'd652;        5'd21: v = 32'd326;
      5'd22: v = 32'd163;        5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

// File: rtl/atf_ctrl.sv
// Sequencer for the arc triangle fan tessellator
module atf_ctrl
  import atf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  atf_sts_t sts,
  output atf_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_DIV = 4'd2, S_ANG = 4'd3,
                         S_CINIT = 4'd4, S_COR = 4'd5, S_MULX = 4'd6, S_MULY = 4'd7,
                         S_PLY = 4'd9, S_EMIT = 4'd10, S_DSTART = 4'd11;
  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = sts.empty ? S_IDLE : S_ANG;
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_ANG;
      end
      S_ANG: begin
        cmd.ang_load = 1'b1;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.cor_init = 1'b1;
        state_nxt = S_COR;
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        if (sts.cor_done) state_nxt = S_MULX;
      end
      S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        // place x from the product taken last cycle while y is multiplied
        cmd.mul_y = 1'b1;
        cmd.place_x = 1'b1;
        state_nxt = S_PLY;
      end
      S_PLY: begin
        cmd.place_y = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // start point only seeds prev; later points emit a triangle
        if (sts.first) begin
          cmd.shift_prev = 1'b1;
          cmd.k_inc = 1'b1;
          state_nxt = S_DSTART;
        end else if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.shift_prev = 1'b1;
          cmd.k_inc = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_DSTART;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// File: rtl/atf_dp.sv
// Datapath: divider, cordic, scaling and output register
module atf_dp
  import atf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  atf_cmd_t           cmd,
  output atf_sts_t           sts,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_radius,
  input  logic [15:0]        in_start_angle,
  input  logic [16:0]        in_arc_angle,
  input  logic [6:0]         in_segments,
  input  logic [31:0]        in_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_next_x,
  output logic signed [31:0] out_next_y,
  output logic signed [31:0] out_prev_x,
  output logic signed [31:0] out_prev_y,
  output logic signed [31:0] out_hub_x,
  output logic signed [31:0] out_hub_y,
  output logic [31:0]        out_vertex_color,
  output logic               out_last_triangle
);
  logic signed [31:0] cx_r, cy_r;
  logic [30:0]        rad_r;
  logic [15:0]        start_r;
  logic [16:0]        arc_r;
  logic [SegW-1:0]    segs_r;
  logic [31:0]        color_r;
  logic [SegW-1:0]    k_r;
  // arc*k numerator (up to 2^16*64 = 2^22), quotient and remainder
  logic [22:0]        num_r;
  logic [16:0]        quo_r;
  logic [SegW:0]      rem_r;
  logic [4:0]         dcnt_r;
  logic [15:0]        ang_r;
  logic [1:0]         quad_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [StepW-1:0]   ccnt_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] nx_r, ny_r, px_r, py_r;
  logic               ovalid_r;
  logic               olast_r;
  logic signed [31:0] onx_r, ony_r, opx_r, opy_r;

  logic [16:0]     arc_c;
  logic [SegW-1:0] segs_c;
  logic [SegW:0]   rem_sh;
  logic [SegW:0]   rem_sub;
  logic signed [33:0] dx, dy;
  logic signed [33:0] ux_c, uy_c;

  assign arc_c  = (in_arc_angle > 17'h10000) ? 17'h10000 : in_arc_angle;
  assign segs_c = (in_segments > SegW'(MaxSegments)) ? SegW'(MaxSegments) : in_segments;

  assign rem_sh  = {rem_r[SegW-1:0], num_r[22]};
  assign rem_sub = rem_sh - {1'b0, segs_r};
  assign dx = y_r >>> ccnt_r;
  assign dy = x_r >>> ccnt_r;

  // map the rotated vector into its quadrant
  always_comb begin
    unique case (quad_r)
      2'd0: begin ux_c = x_r;  uy_c = y_r;  end
      2'd1: begin ux_c = -y_r; uy_c = x_r;  end
      2'd2: begin ux_c = -x_r; uy_c = -y_r; end
      default: begin ux_c = y_r; uy_c = -x_r; end
    endcase
  end

  assign sts.empty    = (rad_r == '0) || (arc_r == '0) || (segs_r < SegW'(MinSegments));
  assign sts.div_done = (dcnt_r == 5'd22);
  assign sts.cor_done = (ccnt_r == StepW'(CordicSteps - 1));
  assign sts.first    = (k_r == '0);
  assign sts.last     = (k_r == segs_r);
  assign sts.out_busy = ovalid_r && !out_ready;

  // saturating placement
  function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                               input logic signed [65:0] p);
    logic signed [65:0] off;
    logic signed [66:0] sum;
    off = (p + 66'sd536870912) >>> 30;
    sum = 67'(c) + 67'(off);
    if (sum > 67'sd2147483647) return 32'sh7fffffff;
    if (sum < -67'sd2147483648) return 32'sh80000000;
    return sum[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      rad_r <= in_radius;
      start_r <= in_start_angle;
      arc_r <= arc_c;
      segs_r <= segs_c;
      color_r <= in_color;
      k_r <= '0;
    end
    if (cmd.k_inc) k_r <= k_r + 1'b1;
    // restoring divide of arc*(k) by segments, one bit per cycle
    if (cmd.div_start) begin
      num_r <= 23'(arc_r) * 23'(k_r);
      quo_r <= '0;
      rem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[21:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
      if (!rem_sub[SegW]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[15:0], 1'b0};
      end
    end
    if (cmd.ang_load) ang_r <= (k_r == '0) ? start_r : start_r + quo_r[15:0];
    if (cmd.cor_init) begin
      quad_r <= ang_r[15:14];
      z_r <= 34'({ang_r[13:0], 16'd0});
      x_r <= GainInv;
      y_r <= '0;
      ccnt_r <= '0;
    end else if (cmd.cor_step) begin
      ccnt_r <= ccnt_r + 1'b1;
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - 34'(atan_lut(ccnt_r));
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + 34'(atan_lut(ccnt_r));
      end
    end
    // one shared multiplier: x product first, then y
    if (cmd.mul_x) prod_r <= $signed({1'b0, rad_r}) * ux_c;
    else if (cmd.mul_y) prod_r <= $signed({1'b0, rad_r}) * uy_c;
    if (cmd.place_x) nx_r <= place(cx_r, prod_r);
    if (cmd.place_y) ny_r <= place(cy_r, prod_r);
    if (cmd.shift_prev) begin
      px_r <= nx_r;
      py_r <= ny_r;
    end
    if (cmd.emit) begin
      onx_r <= nx_r;
      ony_r <= ny_r;
      opx_r <= px_r;
      opy_r <= py_r;
      out_hub_x <= cx_r;
      out_hub_y <= cy_r;
      out_vertex_color <= color_r;
      olast_r <= (k_r == segs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;
  assign out_next_x = onx_r;
  assign out_next_y = ony_r;
  assign out_prev_x = opx_r;
  assign out_prev_y = opy_r;
  assign out_last_triangle = olast_r;
endmodule

// File: rtl/arc_triangle_fan_tessellator_unit.sv
// Top level of the arc triangle fan tessellator
//
//  channel | handshake            | payload
//  in_     | in_valid / in_ready  | centre, radius, angles, segments, color
//  out_    | out_valid / out_ready| next, prev, hub vertices, color, last flag
//
// One request at a time. The start point runs angle, seed, the CORDIC
// loop, two multiplies and placement; every later rim point first runs the
// serial divide, so the time per request is set by the serial divide and
// CORDIC loops. An empty request emits no triangle. Reset is synchronous,
// active low.
// A stalled output register holds the sequencer before the next emit.
module arc_triangle_fan_tessellator_unit
  import atf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_radius,
  input  logic [15:0]        in_start_angle,
  input  logic [16:0]        in_arc_angle,
  input  logic [6:0]         in_segments,
  input  logic [31:0]        in_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_next_x,
  output logic signed [31:0] out_next_y,
  output logic signed [31:0] out_prev_x,
  output logic signed [31:0] out_prev_y,
  output logic signed [31:0] out_hub_x,
  output logic signed [31:0] out_hub_y,
  output logic [31:0]        out_vertex_color,
  output logic               out_last_triangle
);
  atf_cmd_t cmd;
  atf_sts_t sts;

  // sequencer: walks divide, rotate, scale and emit per rim point
  atf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  // datapath: holds the request and produces each triangle
  atf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_radius(in_radius),
    .in_start_angle(in_start_angle), .in_arc_angle(in_arc_angle),
    .in_segments(in_segments), .in_color(in_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_next_x(out_next_x), .out_next_y(out_next_y),
    .out_prev_x(out_prev_x), .out_prev_y(out_prev_y),
    .out_hub_x(out_hub_x), .out_hub_y(out_hub_y),
    .out_vertex_color(out_vertex_color), .out_last_triangle(out_last_triangle)
  );
endmodule

// File: rtl/atf_checker.sv
// Port-level checks for the arc triangle fan tessellator
`include "arc_triangle_fan_tessellator_unit_defines.svh"
module atf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_x,
  input logic        out_last_triangle
);
  // a stalled result stays valid
  `ATF_ASSERT_NEXT(out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // a stalled result keeps its payload
  `ATF_ASSERT_NEXT(out_stable, clk, rst_n, out_valid && !out_ready,
    $stable(out_next_x) && $stable(out_last_triangle))
  // after an accepted request the input side is busy
  `ATF_ASSERT_NEXT(busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // an idle block stays open until a request arrives
  `ATF_ASSERT_NEXT(idle_holds, clk, rst_n, in_ready && !in_valid, in_ready)
endmodule

bind arc_triangle_fan_tessellator_unit atf_checker u_atf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_next_x(out_next_x),
  .out_last_triangle(out_last_triangle)
);

// File: sim/arc_fan_checker.sv
// Checker for the arc triangle fan tessellator: predicts triangles and compares them
`timescale 1ns / 1ps
module arc_fan_checker
  import atf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_radius,
  input  logic [15:0]        in_start_angle,
  input  logic [16:0]        in_arc_angle,
  input  logic [6:0]         in_segments,
  input  logic [31:0]        in_color,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_next_x,
  input  logic signed [31:0] out_next_y,
  input  logic signed [31:0] out_prev_x,
  input  logic signed [31:0] out_prev_y,
  input  logic signed [31:0] out_hub_x,
  input  logic signed [31:0] out_hub_y,
  input  logic [31:0]        out_vertex_color,
  input  logic               out_last_triangle,
  output int                 fail_count,
  output int                 pending_count
);
  typedef struct packed {
    logic signed [31:0] nx, ny, px, py, hx, hy;
    logic [31:0]        col;
    logic               last;
  } triangle_t;

  triangle_t tri_q[$];

  function automatic longint floor_sr(longint v, int s);
    return v >>> s;
  endfunction

  // rotate from quadrant remainder, then map the quadrant
  function automatic void sin_cos(input logic [15:0] ang, output longint cv, output longint sv);
    logic [31:0] t;
    longint x, y, z, dx, dy;
    logic [1:0] quad;
    t = {ang, 16'h0};
    quad = t[31:30];
    z = longint'(t[29:0]);
    x = longint'(GainInv);
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = floor_sr(y, i);
      dy = floor_sr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i[StepW-1:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i[StepW-1:0]));
      end
    end
    case (quad)
      2'd0: begin cv = x;  sv = y;  end
      2'd1: begin cv = -y; sv = x;  end
      2'd2: begin cv = -x; sv = -y; end
      default: begin cv = y; sv = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] rim_coord(longint ctr, longint rad, longint u);
    longint sum;
    sum = ctr + floor_sr(rad * u + (64'sd1 <<< 29), 30);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  task automatic predict_fan();
    longint cx, cy, rad, c, s;
    longint unsigned arc, segs, ang;
    triangle_t t;
    logic signed [31:0] px, py;
    cx = longint'(in_center_x);
    cy = longint'(in_center_y);
    rad = longint'({1'b0, in_radius});
    arc = in_arc_angle;
    segs = in_segments;
    if (arc > 65536) arc = 65536;
    if (segs > MaxSegments) segs = MaxSegments;
    if (rad == 0 || arc == 0 || segs < MinSegments) return;
    sin_cos(in_start_angle, c, s);
    px = rim_coord(cx, rad, c);
    py = rim_coord(cy, rad, s);
    for (longint unsigned k = 0; k < segs; k++) begin
      ang = (in_start_angle + (arc * (k + 1)) / segs) & 64'hFFFF;
      sin_cos(ang[15:0], c, s);
      t.nx = rim_coord(cx, rad, c);
      t.ny = rim_coord(cy, rad, s);
      t.px = px;
      t.py = py;
      t.hx = in_center_x;
      t.hy = in_center_y;
      t.col = in_color;
      t.last = (k + 1 == segs);
      tri_q = {tri_q, t};
      px = t.nx;
      py = t.ny;
    end
  endtask

  always @(posedge clk) begin
    triangle_t e;
    if (!rst_n) begin
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready) predict_fan();
      if (out_valid && out_ready) begin
        if (tri_q.size() == 0) begin
          $error("unexpected triangle");
          fail_count <= fail_count + 1;
        end else begin
          e = tri_q.pop_front();
          if (out_next_x !== e.nx || out_next_y !== e.ny || out_prev_x !== e.px ||
              out_prev_y !== e.py || out_hub_x !== e.hx || out_hub_y !== e.hy ||
              out_vertex_color !== e.col || out_last_triangle !== e.last)
            fail_count <= fail_count + 1;
          if (out_next_x !== e.nx) $error("next_x exp %0d got %0d", e.nx, out_next_x);
          if (out_next_y !== e.ny) $error("next_y exp %0d got %0d", e.ny, out_next_y);
          if (out_prev_x !== e.px) $error("prev_x exp %0d got %0d", e.px, out_prev_x);
          if (out_prev_y !== e.py) $error("prev_y exp %0d got %0d", e.py, out_prev_y);
          if (out_hub_x !== e.hx) $error("hub_x exp %0d got %0d", e.hx, out_hub_x);
          if (out_hub_y !== e.hy) $error("hub_y exp %0d got %0d", e.hy, out_hub_y);
          if (out_vertex_color !== e.col)
            $error("vertex_color exp %h got %h", e.col, out_vertex_color);
          if (out_last_triangle !== e.last)
            $error("last_triangle exp %0d got %0d", e.last, out_last_triangle);
        end
      end
      pending_count <= tri_q.size();
    end
  end
endmodule

// File: sim/arc_triangle_fan_tessellator_unit_test.sv
// Top of the arc triangle fan tessellator testbench: stimulus and verdict
`timescale 1ns / 1ps
module arc_triangle_fan_tessellator_unit_test;
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_center_x = '0;
  logic signed [31:0] in_center_y = '0;
  logic [30:0]        in_radius = '0;
  logic [15:0]        in_start_angle = '0;
  logic [16:0]        in_arc_angle = '0;
  logic [6:0]         in_segments = '0;
  logic [31:0]        in_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_next_x, out_next_y, out_prev_x, out_prev_y;
  logic signed [31:0] out_hub_x, out_hub_y;
  logic [31:0]        out_vertex_color;
  logic               out_last_triangle;
  int                 fail_count, pending_count;
  int                 cycle_count = 0;
  // hold the receiver off while set, counted out in its own process
  bit                 sink_hold = 1'b0;
  bit                 sink_quiet = 1'b0;

  // Each request carries up to 64 triangles, and random receiver gaps
  // stretch the time that each triangle takes to leave the block.
  localparam int CycleLimit = 20_000_000;

  always #2 clk = ~clk;

  arc_triangle_fan_tessellator_unit i_dut (.*);

  arc_fan_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("arc_triangle_fan_tessellator_unit_test failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 4);
  endfunction

  // Receiver: random readiness, with a long hold when requested.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (6000) @(negedge clk);
        sink_hold = 1'b0;
      end else if (sink_quiet) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        g = gap_len() + 1;
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send_req(logic signed [31:0] cx, logic signed [31:0] cy, logic [30:0] r,
                          logic [15:0] st, logic [16:0] arc, logic [6:0] sg, logic [31:0] col);
    @(negedge clk);
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    in_start_angle <= st;
    in_arc_angle <= arc;
    in_segments <= sg;
    in_color <= col;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_random(bit well_formed);
    logic [30:0] r;
    logic [16:0] arc;
    logic [6:0]  sg;
    // keep most fans small; some use the full segment range
    sg = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(3, 127)) : 7'($urandom_range(3, 10));
    r = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 24));
    arc = 17'($urandom_range(1, 131071));
    if (!well_formed) begin
      case ($urandom_range(0, 2))
        0: r = '0;
        1: arc = '0;
        default: sg = 7'($urandom_range(0, 2));
      endcase
    end
    send_req($urandom, $urandom, r, 16'($urandom), arc, sg, $urandom);
  endtask

  initial begin
    int g;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full circle, extremes, empty cases, saturation
    send_req(32'sd0, 32'sd0, 31'h0001_0000, 16'd0, 17'd65536, 7'd4, 32'hFFFF_FFFF);
    send_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 16'd0, 17'd65536, 7'd8, 32'h0);
    send_req(-32'sh8000_0000, -32'sh8000_0000, 31'h7FFF_FFFF, 16'hFFFF, 17'h1FFFF, 7'd127,
             32'h1234_5678);
    send_req(32'sd100, 32'sd200, 31'd0, 16'd0, 17'd65536, 7'd8, 32'hAA);
    send_req(32'sd100, 32'sd200, 31'd500, 16'd0, 17'd0, 7'd8, 32'hBB);
    send_req(32'sd100, 32'sd200, 31'd500, 16'd0, 17'd65536, 7'd2, 32'hCC);
    send_req(32'sd100, 32'sd200, 31'd500, 16'd0, 17'd65536, 7'd0, 32'hCD);
    send_req(32'sd5, -32'sd5, 31'd1, 16'h4000, 17'd1, 7'd3, 32'h5555_AAAA);
    send_req(32'sd0, 32'sd0, 31'h0010_0000, 16'h8000, 17'd65535, 7'd64, 32'hAAAA_5555);
    send_req(32'sd0, 32'sd0, 31'h0010_0000, 16'hC000, 17'd65537, 7'd65, 32'h0F0F_0F0F);
    send_req(-32'sd1, 32'sd1, 31'h4000_0000, 16'h2000, 17'd16384, 7'd3, 32'hF0F0_F0F0);

    // pause until every expected triangle has come
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    // long receiver hold while requests keep coming
    sink_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_random(1'b1);

    for (int i = 0; i < 400; i++) begin
      // stretch with no idling on either side
      sink_quiet = (i >= 200 && i < 240);
      send_random($urandom_range(0, 9) != 0);
      if (!sink_quiet) begin
        g = gap_len();
        repeat (g) @(negedge clk);
      end
    end
    sink_quiet = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("arc_triangle_fan_tessellator_unit_test passed");
    else
      $display("arc_triangle_fan_tessellator_unit_test failed");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/atf_pkg.sv
rtl/atf_ctrl.sv
rtl/atf_dp.sv
rtl/arc_triangle_fan_tessellator_unit.sv
rtl/atf_checker.sv
sim/arc_fan_checker.sv
sim/arc_triangle_fan_tessellator_unit_test.sv
